// File: rtl/core/best_split_positional_cost_top_defines.svh
// Assertion macros for the best split positional cost block.
// Included by files that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef BEST_SPLIT_POSITIONAL_COST_TOP_DEFINES_SVH
`define BEST_SPLIT_POSITIONAL_COST_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BSPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bspc_pkg.sv
// Shared widths, defaults and word types for the best split positional cost block.
// No dependencies; used by bspc_datapath and best_split_positional_cost_top.
package bspc_pkg;

	localparam int CNT_W = 11;
	localparam int WEIGHT_W = 16;
	localparam int COST_W = 36;
	localparam int FAC_W = CNT_W + 2;
	localparam int PD_W = WEIGHT_W + 1 + FAC_W;
	localparam int PR_W = WEIGHT_W + CNT_W;
	localparam int DIFF_W = PD_W + CNT_W;
	localparam int OUT_DATA_W = ((CNT_W + COST_W + 7) / 8) * 8;

	localparam int DEF_MAX_ITEMS = 1024;
	localparam int DEF_WEIGHT_BITS = 16;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] n;
		logic last;
	} bspc_item_t;

	typedef struct packed {
		logic [COST_W-1:0] best_cost;
		logic [CNT_W-1:0] split_index;
	} bspc_res_t;

endpackage

// File: rtl/core/best_split_positional_cost_top.sv
// Best split positional cost: top level with stream ports, count register and result word.
// Depends on bspc_pkg, bspc_datapath and best_split_positional_cost_top_defines.svh.
//
// Usage: write the sequence length n through cfg_wen/cfg_wdata while the block is idle;
// zero acts as one and a value above MAX_ITEMS acts as MAX_ITEMS. A write drops any
// sequence in progress. Weights then stream in on the s_ side, one word per cycle
// while s_tready is high. After the n-th weight one result word leaves on the m_ side
// with the lowest split point of minimum cost and that cost; other weights give no result.
// Path: the result word passes the s1, s2 and s3 registers and then the result register.
// Throughput: one weight per cycle while s_tready is high; the multiply stage, the joint
// accumulate and compare stage and the result register are pipelined; nothing recirculates.
// Reset: the count returns to one and the running sums and position clear.
// Stall: while a result waits in the result register and another finished result
// reaches the final stage, the whole pipeline holds and s_tready drops; otherwise
// weights keep flowing while the receiver stalls.
`include "best_split_positional_cost_top_defines.svh"
module best_split_positional_cost_top #(
	parameter int MAX_ITEMS = bspc_pkg::DEF_MAX_ITEMS,
	parameter int WEIGHT_BITS = bspc_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [bspc_pkg::WEIGHT_W-1:0] s_tdata, // [15:0] weight
	output logic m_tvalid,
	input logic m_tready,
	output logic [bspc_pkg::OUT_DATA_W-1:0] m_tdata, // [10:0] split_index, [46:11] best_cost
	input logic cfg_wen,
	input logic [bspc_pkg::CNT_W-1:0] cfg_wdata
);
	import bspc_pkg::*;

	localparam int EFF_BITS = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
	localparam logic [WEIGHT_W-1:0] WMASK = WEIGHT_W'((64'd1 << EFF_BITS) - 64'd1);

	logic [CNT_W-1:0] n_q, pos_q, n_wr;
	logic adv, acc, last, res_valid, out_v_q;
	bspc_item_t item;
	bspc_res_t res, out_q;

	always_comb begin
		if (cfg_wdata == '0)
			n_wr = CNT_W'(1);
		else if (32'(cfg_wdata) > MAX_ITEMS)
			n_wr = CNT_W'(MAX_ITEMS);
		else
			n_wr = cfg_wdata;
	end

	assign adv = !(res_valid && out_v_q && !m_tready);
	assign s_tready = adv;
	assign acc = s_tvalid && adv;
	assign last = (pos_q + CNT_W'(1)) == n_q;

	always_comb begin
		item.weight = s_tdata & WMASK;
		item.pos = pos_q;
		item.n = n_q;
		item.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CNT_W'(1);
			pos_q <= '0;
		end else if (cfg_wen) begin
			n_q <= n_wr;
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= last ? '0 : pos_q + CNT_W'(1);
		end
	end

	bspc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.clr(cfg_wen),
		.in_valid(acc),
		.in_item(item),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid && adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {{(OUT_DATA_W - CNT_W - COST_W){1'b0}}, out_q.best_cost, out_q.split_index};

	`BSPC_ASSERT_NOW(a_pos_below_count, 1'b1, pos_q < n_q, "position reached the count")
	`BSPC_ASSERT_NOW(a_count_nonzero, 1'b1, n_q != '0, "sequence length is zero")
	`BSPC_ASSERT_NEXT(a_result_loaded, res_valid && adv, out_v_q, "finished result not loaded")
	`BSPC_ASSERT_NOW(a_split_in_range, out_v_q, out_q.split_index <= n_q, "split beyond length")

endmodule

// File: rtl/core/bspc_datapath.sv
// Multiply, accumulate and best-split tracking pipeline of the positional cost block.
// Depends on bspc_pkg.
module bspc_datapath (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic clr,
	input logic in_valid,
	input bspc_pkg::bspc_item_t in_item,
	output logic res_valid,
	output bspc_pkg::bspc_res_t res
);
	import bspc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic [WEIGHT_W-1:0] w_s1;
	logic [CNT_W-1:0] i_s1, n_s1, i_s2;
	logic last_s1, last_s2;
	logic signed [PD_W-1:0] pd_s2;
	logic [PR_W-1:0] pr_s2;

	logic signed [DIFF_W-1:0] d_q, best_q, best_s3;
	logic [COST_W-1:0] r_q, r_s3;
	logic [CNT_W-1:0] bidx_q, idx_s3;

	logic signed [FAC_W-1:0] fac_d;
	logic [CNT_W-1:0] fac_r;
	logic signed [PD_W-1:0] pd;
	logic [PR_W-1:0] pr;
	logic signed [DIFF_W-1:0] d_new, best_sel;
	logic [COST_W-1:0] r_new;
	logic [CNT_W-1:0] idx_new, idx_sel;
	logic better;

	always_comb begin
		fac_d = $signed({1'b0, i_s1, 1'b0}) - $signed({2'b00, n_s1});
		fac_r = n_s1 - i_s1;
		pd = $signed({1'b0, w_s1}) * fac_d;
		pr = w_s1 * fac_r;
	end

	always_comb begin
		d_new = d_q + {{(DIFF_W - PD_W){pd_s2[PD_W-1]}}, pd_s2};
		r_new = r_q + {{(COST_W - PR_W){1'b0}}, pr_s2};
		idx_new = i_s2 + CNT_W'(1);
		better = d_new < best_q;
		best_sel = better ? d_new : best_q;
		idx_sel = better ? idx_new : bidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= in_item.weight;
			i_s1 <= in_item.pos;
			n_s1 <= in_item.n;
			last_s1 <= in_item.last;
			pd_s2 <= pd;
			pr_s2 <= pr;
			i_s2 <= i_s1;
			last_s2 <= last_s1;
			if (v_s2 && last_s2) begin
				r_s3 <= r_new;
				best_s3 <= best_sel;
				idx_s3 <= idx_sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
			r_q <= '0;
			best_q <= '0;
			bidx_q <= '0;
		end else if (clr || (adv && v_s2 && last_s2)) begin
			d_q <= '0;
			r_q <= '0;
			best_q <= '0;
			bidx_q <= '0;
		end else if (adv && v_s2) begin
			d_q <= d_new;
			r_q <= r_new;
			best_q <= best_sel;
			bidx_q <= idx_sel;
		end
	end

	assign res_valid = v_s3;
	assign res.split_index = idx_s3;
	assign res.best_cost = r_s3 + best_s3[COST_W-1:0];

endmodule

// File: tb/tb.sv
// Self-checking testbench for best_split_positional_cost_top: streams weight sequences of
// many lengths and checks each split index and cost against a predictor kept in the bench.
// Depends on bspc_pkg and the block's RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bspc_pkg::*;

	localparam int LATENCY = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WEIGHTS = 260;

	typedef enum int {W_ANY, W_EDGE, W_LOW, W_FLAT} weight_mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid;
	logic s_tready;
	logic [WEIGHT_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_wen;
	logic [CNT_W-1:0] cfg_wdata;

	// predictor state
	logic [CNT_W-1:0] len_reg;
	logic [CNT_W-1:0] seq_pos;
	logic signed [37:0] run_diff;
	logic [COST_W-1:0] right_sum;
	logic signed [37:0] best_diff;
	logic [CNT_W-1:0] best_split;

	bspc_res_t expected_splits[$];
	bspc_res_t head_split;
	int errors = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;

	best_split_positional_cost_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(3, 24);
	endfunction

	function automatic longint eff_len(input logic [CNT_W-1:0] v);
		if (int'(v) == 0)
			return 1;
		if (int'(v) > DEF_MAX_ITEMS)
			return DEF_MAX_ITEMS;
		return longint'(v);
	endfunction

	function automatic void clear_split();
		seq_pos = '0;
		run_diff = '0;
		right_sum = '0;
		best_diff = '0;
		best_split = '0;
	endfunction

	function automatic void track_split(input logic [WEIGHT_W-1:0] w);
		longint n;
		longint pos;
		bspc_res_t res;
		n = eff_len(len_reg);
		pos = longint'(seq_pos);
		run_diff = 38'(longint'(run_diff) + longint'(w) * (2 * pos - n));
		right_sum = 36'(longint'(right_sum) + longint'(w) * (n - pos));
		seq_pos = seq_pos + CNT_W'(1);
		if (run_diff < best_diff) begin
			best_diff = run_diff;
			best_split = seq_pos;
		end
		if (longint'(seq_pos) >= n) begin
			res.split_index = best_split;
			res.best_cost = 36'(longint'(right_sum) + longint'(best_diff));
			expected_splits.push_back(res);
			clear_split();
		end
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight(input weight_mix_t mix);
		case (mix)
			W_EDGE: return $urandom_range(0, 1) ? {WEIGHT_W{1'b1}} : '0;
			W_LOW: return WEIGHT_W'($urandom_range(0, 3));
			default: return WEIGHT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_weight(input logic [WEIGHT_W-1:0] w);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do
			@(posedge clk);
		while (!s_tready);
		track_split(w);
	endtask

	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_splits.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_item_count(input logic [CNT_W-1:0] v);
		wait_results();
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		len_reg = v;
		clear_split();
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_unit_count();
		send_weight('0);
		send_weight({WEIGHT_W{1'b1}});
		send_weight(16'h8000);
		send_weight(16'h0001);
	endtask

	task automatic test_zero_count();
		set_item_count('0);
		send_weight(16'h5555);
		send_weight(16'hAAAA);
	endtask

	task automatic test_ties();
		set_item_count(11'd2);
		send_weight(16'd7);
		send_weight(16'd7);
		send_weight(16'd0);
		send_weight(16'd0);
		set_item_count(11'd4);
		send_weight(16'd3);
		send_weight(16'd0);
		send_weight(16'd0);
		send_weight(16'd3);
	endtask

	task automatic test_restart_on_write();
		set_item_count(11'd5);
		send_weight(16'd100);
		send_weight(16'd200);
		send_weight(16'd300);
		set_item_count(11'd3);
		send_weight(16'hFFFF);
		send_weight(16'h0000);
		send_weight(16'hFFFF);
	endtask

	task automatic test_count_clamp();
		tx_gaps = 1'b0;
		set_item_count(11'd2047);
		repeat (DEF_MAX_ITEMS) send_weight({WEIGHT_W{1'b1}});
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_sequences();
		int sent;
		int r;
		int n_raw;
		int len;
		int seqs;
		int k;
		weight_mix_t mix;
		logic [WEIGHT_W-1:0] flat;
		sent = 0;
		while (sent < RANDOM_WEIGHTS) begin
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			r = $urandom_range(0, 19);
			if (r < 13)
				n_raw = $urandom_range(1, 12);
			else if (r < 17)
				n_raw = $urandom_range(13, 64);
			else if (r < 19)
				n_raw = $urandom_range(65, 160);
			else
				n_raw = 0;
			set_item_count(CNT_W'(n_raw));
			len = (n_raw == 0) ? 1 : n_raw;
			seqs = $urandom_range(1, 6);
			repeat (seqs) begin
				mix = weight_mix_t'($urandom_range(0, 3));
				flat = WEIGHT_W'($urandom);
				for (k = 0; k < len; k++)
					send_weight(mix == W_FLAT ? flat : pick_weight(mix));
				sent += len;
				if ($urandom_range(0, 9) == 0)
					wait_results();
			end
			// leave a sequence unfinished so the next write drops it
			if (len > 1 && $urandom_range(0, 4) == 0) begin
				k = $urandom_range(1, len - 1);
				repeat (k) send_weight(pick_weight(W_ANY));
				sent += k;
			end
		end
	endtask

	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_stalls && $urandom_range(0, 3) == 0)
					hold_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_splits.size() == 0) begin
				$error("m_tdata: result word with none expected");
				errors++;
			end else begin
				head_split = expected_splits.pop_front();
				if (m_tdata[CNT_W-1:0] !== head_split.split_index) begin
					$error("split_index: expected %0d, got %0d", head_split.split_index,
						m_tdata[CNT_W-1:0]);
					errors++;
				end
				if (m_tdata[CNT_W +: COST_W] !== head_split.best_cost) begin
					$error("best_cost: expected %0d, got %0d", head_split.best_cost,
						m_tdata[CNT_W +: COST_W]);
					errors++;
				end
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		len_reg = 11'd1;
		clear_split();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_unit_count();
		test_zero_count();
		test_ties();
		test_restart_on_write();
		test_count_clamp();
		test_random_sequences();
		wait_results();
		repeat (LATENCY + 6) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
